@@ rtl/rsfr_pkg.sv @@
// Package for the RTU silence frame receiver.
// Holds request codes, register indexes, mode encoding and shared structs.
// No dependencies.
package rsfr_pkg;

    // Request codes on the input channel
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Receiver state codes as reported on the result channel
    localparam logic [1:0] STATE_INIT = 2'd0;
    localparam logic [1:0] STATE_IDLE = 2'd1;
    localparam logic [1:0] STATE_RCV  = 2'd2;

    // Configuration register map
    localparam int          PADDR_W       = 3;
    localparam logic        REG_END_TICKS = 1'b0;
    localparam logic        REG_GAP_TICKS = 1'b1;
    localparam logic [3:0]  END_TICKS_RST = 4'd7;
    localparam logic [3:0]  GAP_TICKS_RST = 4'd3;

    typedef enum logic [2:0] {
        MODE_INIT = 3'b001,
        MODE_IDLE = 3'b010,
        MODE_RCV  = 3'b100
    } rx_mode_t;

    typedef struct packed {
        logic [3:0] end_ticks;
        logic [3:0] gap_ticks;
    } cfg_regs_t;

    typedef struct packed {
        logic       frame_ready;
        logic [8:0] frame_length;
        logic [7:0] late_gap_count;
        logic [1:0] receiver_state;
        logic       overflow;
    } rx_status_t;

endpackage

@@ rtl/rsfr_if.sv @@
// Valid/ready channel interfaces for the RTU silence frame receiver.
// Depends on nothing; request and result payloads at fixed widths.
interface rsfr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic       line_error;
    logic [7:0] read_index;

    modport source (output valid, req_type, rx_byte, line_error, read_index, input ready);
    modport sink   (input valid, req_type, rx_byte, line_error, read_index, output ready);
endinterface

interface rsfr_rsp_if;
    logic       valid;
    logic       ready;
    logic       frame_ready;
    logic [8:0] frame_length;
    logic [7:0] late_gap_count;
    logic [7:0] read_data;
    logic [1:0] receiver_state;
    logic       overflow;

    modport source (output valid, frame_ready, frame_length, late_gap_count, read_data,
                    receiver_state, overflow, input ready);
    modport sink   (input valid, frame_ready, frame_length, late_gap_count, read_data,
                    receiver_state, overflow, output ready);
endinterface

@@ rtl/rsfr_cfg.sv @@
// APB-style configuration registers: end_ticks and gap_ticks.
// Depends on rsfr_pkg.
module rsfr_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsfr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output rsfr_pkg::cfg_regs_t           cfg
);
    import rsfr_pkg::*;

    logic [3:0] end_ticks_reg;
    logic [3:0] gap_ticks_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_ticks_reg <= END_TICKS_RST;
            gap_ticks_reg <= GAP_TICKS_RST;
        end
        else if (wr_en)
        begin
            // word index is paddr[2]; byte offset bits are ignored
            if (paddr[2] == REG_END_TICKS)
                end_ticks_reg <= pwdata[3:0];
            else
                gap_ticks_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_END_TICKS)
            prdata[3:0] = end_ticks_reg;
        else
            prdata[3:0] = gap_ticks_reg;
    end

    assign cfg.end_ticks = end_ticks_reg;
    assign cfg.gap_ticks = gap_ticks_reg;

endmodule

@@ rtl/rsfr_ctrl.sv @@
// Frame state sequencer: silence timer, gap tally, byte count and store writes.
// Depends on rsfr_pkg.
module rsfr_ctrl #(
    parameter int FRAME_DEPTH = 256,
    parameter int AW          = 8,
    parameter int CW          = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rsfr_pkg::cfg_regs_t    cfg,
    input  logic                   accept,
    input  logic [1:0]             req_type,
    input  logic [7:0]             rx_byte,
    input  logic                   line_error,
    output rsfr_pkg::rx_status_t   status,
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output logic [7:0]             wr_data
);
    import rsfr_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(FRAME_DEPTH);

    rx_mode_t      mode_reg,    mode_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [3:0]    silence_reg, silence_next;
    logic          running_reg, running_next;
    logic [7:0]    tally_reg,   tally_next;
    logic          ovf_reg,     ovf_next;

    always_comb
    begin
        logic [3:0] sil_inc;
        logic [7:0] tally_inc;
        sil_inc      = silence_reg + 4'd1;
        tally_inc    = (sil_inc == cfg.gap_ticks) ? tally_reg + 8'd1 : tally_reg;
        mode_next    = mode_reg;
        count_next   = count_reg;
        silence_next = silence_reg;
        running_next = running_reg;
        tally_next   = tally_reg;
        ovf_next     = ovf_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_data      = rx_byte;
        status.frame_ready    = 1'b0;
        status.late_gap_count = 8'd0;

        if (accept)
        begin
            unique case (req_type)
                REQ_BYTE:
                begin
                    if (!line_error)
                    begin
                        silence_next = 4'd0;
                        running_next = 1'b1;
                        unique case (mode_reg)
                            MODE_INIT: ;
                            MODE_IDLE:
                            begin
                                mode_next  = MODE_RCV;
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                count_next = CW'(1);
                                ovf_next   = 1'b0;
                                tally_next = 8'd0;
                            end
                            MODE_RCV:
                            begin
                                if (count_reg < DEPTH_C)
                                begin
                                    wr_en      = 1'b1;
                                    count_next = count_reg + CW'(1);
                                end
                                else
                                    ovf_next = 1'b1;
                            end
                            default: mode_next = MODE_INIT;
                        endcase
                    end
                end
                REQ_TICK:
                begin
                    if (running_reg)
                    begin
                        silence_next = sil_inc;
                        tally_next   = tally_inc;
                        if (sil_inc == cfg.end_ticks)
                        begin
                            // the final gap also reached gap_ticks; leave it out
                            if (mode_reg == MODE_RCV)
                            begin
                                status.frame_ready    = 1'b1;
                                status.late_gap_count = (tally_inc != 8'd0) ?
                                                        tally_inc - 8'd1 : 8'd0;
                            end
                            mode_next    = MODE_IDLE;
                            running_next = 1'b0;
                            tally_next   = 8'd0;
                        end
                    end
                end
                default: ;
            endcase
        end

        status.frame_length = 9'(count_next);
        status.overflow     = ovf_next;
        unique case (mode_next)
            MODE_INIT: status.receiver_state = STATE_INIT;
            MODE_IDLE: status.receiver_state = STATE_IDLE;
            MODE_RCV:  status.receiver_state = STATE_RCV;
            default:   status.receiver_state = STATE_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_INIT;
            count_reg   <= '0;
            silence_reg <= 4'd0;
            running_reg <= 1'b0;
            tally_reg   <= 8'd0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            silence_reg <= silence_next;
            running_reg <= running_next;
            tally_reg   <= tally_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

@@ rtl/rsfr_store.sv @@
// Frame byte store: one write port, one registered read port.
// No dependencies.
module rsfr_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // held while no new read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rtu_silence_frame_receiver_top.sv @@
// RTU silence frame receiver: frames cut by line silence, bytes kept in a store.
// Result path: store read and status registered on the accepting edge, then moved
// to the output register once it is free or draining. The store has one write and
// one read port. Throughput: one request per cycle unless the result channel stalls.
// Reset: rst_n async, clears mode, counters, tally, flags and pipeline valids;
// end_ticks resets to 7, gap_ticks to 3; store contents are not cleared.
// Depends on rsfr_pkg, rsfr_if, rsfr_cfg, rsfr_ctrl, rsfr_store.
module rtu_silence_frame_receiver_top #(
    parameter int FRAME_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsfr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    rsfr_req_if.sink                      req,
    rsfr_rsp_if.source                    rsp
);
    import rsfr_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);

    cfg_regs_t   cfg;
    rx_status_t  status;
    logic        accept;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic        in_range;
    logic [7:0]  mem_q;

    logic        s1_valid_reg, s1_valid_next;
    rx_status_t  s1_status_reg;
    logic        s1_rd_reg;
    logic        s1_move;

    logic        out_valid_reg, out_valid_next;
    rx_status_t  out_status_reg;
    logic [7:0]  out_rdata_reg;

    rsfr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsfr_ctrl #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .accept     (accept),
        .req_type   (req.req_type),
        .rx_byte    (req.rx_byte),
        .line_error (req.line_error),
        .status     (status),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    assign in_range = ({24'd0, req.read_index} < 32'(FRAME_DEPTH));
    assign rd_en    = accept && (req.req_type == REQ_READ) && in_range;

    rsfr_store #(
        .DEPTH (FRAME_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (AW'(req.read_index)),
        .rd_data (mem_q)
    );

    // two slots: store-read stage and output register
    assign s1_move   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_move;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
            s1_rd_reg     <= rd_en;
        end
        if (s1_move)
        begin
            out_status_reg <= s1_status_reg;
            out_rdata_reg  <= s1_rd_reg ? mem_q : 8'd0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.frame_ready    = out_status_reg.frame_ready;
    assign rsp.frame_length   = out_status_reg.frame_length;
    assign rsp.late_gap_count = out_status_reg.late_gap_count;
    assign rsp.read_data      = out_rdata_reg;
    assign rsp.receiver_state = out_status_reg.receiver_state;
    assign rsp.overflow       = out_status_reg.overflow;

endmodule

@@ tb/tb.sv @@
// Self-checking bench for rtu_silence_frame_receiver_top: a directed table, then random
// frames and noise, predicted by an in-bench receiver model and checked field by field.
// Depends on rsfr_pkg, rsfr_if and the receiver RTL.
module tb;
    import rsfr_pkg::*;

    localparam int         FRAME_DEPTH = 256;
    localparam int         QUIET_LIMIT = 1000;
    localparam int         HOLD_CYCLES = 80;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] rx_byte;
        logic       line_error;
        logic [7:0] read_index;
    } rx_request_t;

    typedef struct packed {
        logic       frame_ready;
        logic [8:0] frame_length;
        logic [7:0] late_gap_count;
        logic [7:0] read_data;
        logic [1:0] receiver_state;
        logic       overflow;
    } rx_result_t;

    typedef struct packed {
        rx_request_t rq;
        logic        typed;
        rx_result_t  want;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    rsfr_req_if req_ch ();
    rsfr_rsp_if rsp_ch ();

    rtu_silence_frame_receiver_top #(.FRAME_DEPTH(FRAME_DEPTH)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // receiver shadow state
    logic [3:0]  end_ticks_cfg = END_TICKS_RST;
    logic [3:0]  gap_ticks_cfg = GAP_TICKS_RST;
    logic [1:0]  mode_q        = STATE_INIT;
    logic [8:0]  stored_q      = '0;
    logic [3:0]  silence_q     = '0;
    logic        timer_on_q    = 1'b0;
    logic [7:0]  gap_tally_q   = '0;
    logic        overflow_q    = 1'b0;
    logic [7:0]  frame_bytes [FRAME_DEPTH];
    int          written_max   = 0;   // entries [0, written_max) have been written

    rx_result_t  status_due [$];
    int          bad_fields    = 0;
    int          items_sent    = 0;
    int          src_idle_pct  = 13;
    int          snk_idle_pct  = 83;
    int          hold_kicks    = 0;
    int          quiet_cycles  = 0;

    plan_row_t directed_plan [26] = '{
        '{'{REQ_TICK, 8'h00, 1'b0, 8'hFF}, 1'b1, '{1'b0, 9'd0, 8'd0, 8'd0, STATE_INIT, 1'b0}},
        '{'{REQ_BYTE, 8'h00, 1'b1, 8'h00}, 1'b1, '{1'b0, 9'd0, 8'd0, 8'd0, STATE_INIT, 1'b0}},
        '{'{REQ_BYTE, 8'hFF, 1'b0, 8'h80}, 1'b1, '{1'b0, 9'd0, 8'd0, 8'd0, STATE_INIT, 1'b0}},
        '{'{REQ_TICK, 8'hFF, 1'b1, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'hFF}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b1, '{1'b0, 9'd0, 8'd0, 8'd0, STATE_IDLE, 1'b0}},
        '{'{REQ_BYTE, 8'hFF, 1'b0, 8'h00}, 1'b1, '{1'b0, 9'd1, 8'd0, 8'd0, STATE_RCV, 1'b0}},
        '{'{REQ_BYTE, 8'h5A, 1'b1, 8'h00}, 1'b0, '0},
        '{'{REQ_BYTE, 8'h00, 1'b0, 8'hFF}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_BYTE, 8'hA5, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_NONE, 8'h7F, 1'b1, 8'hFF}, 1'b0, '0},
        '{'{REQ_READ, 8'h00, 1'b0, 8'h00}, 1'b1, '{1'b0, 9'd3, 8'd0, 8'hFF, STATE_RCV, 1'b0}},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b0, '0},
        '{'{REQ_TICK, 8'h00, 1'b0, 8'h00}, 1'b1, '{1'b1, 9'd3, 8'd1, 8'd0, STATE_IDLE, 1'b0}}
    };

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one accepted request to the shadow receiver and returns its status.
    function automatic rx_result_t advance_receiver(input rx_request_t rq);
        rx_result_t r;
        r = '0;
        case (rq.req)
            REQ_BYTE:
            begin
                if (!rq.line_error)
                begin
                    case (mode_q)
                        STATE_IDLE:
                        begin
                            mode_q         = STATE_RCV;
                            frame_bytes[0] = rq.rx_byte;
                            stored_q       = 9'd1;
                            overflow_q     = 1'b0;
                            gap_tally_q    = '0;
                        end
                        STATE_RCV:
                        begin
                            if (stored_q < FRAME_DEPTH)
                            begin
                                frame_bytes[stored_q[7:0]] = rq.rx_byte;
                                stored_q                   = stored_q + 9'd1;
                            end
                            else
                                overflow_q = 1'b1;
                        end
                        default: ;
                    endcase
                    silence_q  = '0;
                    timer_on_q = 1'b1;
                    if (int'(stored_q) > written_max)
                        written_max = int'(stored_q);
                end
            end
            REQ_TICK:
            begin
                if (timer_on_q)
                begin
                    silence_q = silence_q + 4'd1;
                    // gap check before end check
                    if (silence_q == gap_ticks_cfg)
                        gap_tally_q = gap_tally_q + 8'd1;
                    if (silence_q == end_ticks_cfg)
                    begin
                        if (mode_q == STATE_RCV)
                        begin
                            r.frame_ready    = 1'b1;
                            r.late_gap_count = (gap_tally_q != 0) ? gap_tally_q - 8'd1 : 8'd0;
                        end
                        mode_q      = STATE_IDLE;
                        timer_on_q  = 1'b0;
                        gap_tally_q = '0;
                    end
                end
            end
            REQ_READ:
            begin
                if (rq.read_index < FRAME_DEPTH)
                    r.read_data = frame_bytes[rq.read_index];
            end
            default: ;
        endcase
        r.frame_length   = stored_q;
        r.receiver_state = mode_q;
        r.overflow       = overflow_q;
        return r;
    endfunction

    // Random request; reads only touch entries that some frame has written.
    function automatic rx_request_t random_request(input logic [1:0] kind);
        rx_request_t rq;
        rq.req        = kind;
        rq.rx_byte    = 8'($urandom);
        rq.line_error = ($urandom_range(0, 15) == 0);
        rq.read_index = 8'($urandom);
        if (kind == REQ_READ)
        begin
            if (written_max == 0)
                rq.req = REQ_NONE;
            else
                rq.read_index = 8'($urandom_range(0, written_max - 1));
        end
        return rq;
    endfunction

    function automatic void check_field(input string name, input logic [8:0] want,
                                        input logic [8:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            bad_fields++;
        end
    endfunction

    task automatic send(input rx_request_t rq, input logic typed = 1'b0,
                        input rx_result_t want = '0);
        rx_result_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rq.req;
        req_ch.rx_byte    <= rq.rx_byte;
        req_ch.line_error <= rq.line_error;
        req_ch.read_index <= rq.read_index;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = advance_receiver(rq);
        status_due.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_END_TICKS)
            end_ticks_cfg = value;
        else
            gap_ticks_cfg = value;
    endtask

    task automatic run_phase(input int n_items, input logic [3:0] end_v,
                             input logic [3:0] gap_v, input int src_pct,
                             input int snk_pct, input logic long_frame);
        rx_request_t rq;
        int          target;
        int          ticks_to_end;
        int          nbytes;
        settle();
        write_reg(REG_END_TICKS, end_v);
        write_reg(REG_GAP_TICKS, gap_v);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        // an end setting of 0 is only hit after the 4-bit count wraps
        ticks_to_end = (end_ticks_cfg == 0) ? 16 : int'(end_ticks_cfg);
        if (long_frame)
        begin
            for (int b = 0; b < FRAME_DEPTH + 4; b++)
            begin
                rq            = random_request(REQ_BYTE);
                rq.line_error = 1'b0;
                if (b == 30)
                    hold_kicks <= hold_kicks + 1;
                send(rq);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) send(random_request(REQ_TICK));
            end
            repeat (10) send(random_request(REQ_READ));
            repeat (ticks_to_end) send(random_request(REQ_TICK));
        end
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12);
                for (int b = 0; b < nbytes; b++)
                begin
                    send(random_request(REQ_BYTE));
                    case ($urandom_range(0, 5))
                        0, 1, 2: repeat ($urandom_range(0, ticks_to_end - 1))
                                     send(random_request(REQ_TICK));
                        3: send(random_request(REQ_READ));
                        4: send(random_request(REQ_NONE));
                        default: ;
                    endcase
                end
                repeat (ticks_to_end + $urandom_range(0, 2)) send(random_request(REQ_TICK));
            end
            else
                repeat ($urandom_range(1, 8)) send(random_request(2'($urandom_range(0, 3))));
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_NONE;
        req_ch.rx_byte    <= '0;
        req_ch.line_error <= 1'b0;
        req_ch.read_index <= '0;
        for (int i = 0; i < FRAME_DEPTH; i++)
            frame_bytes[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            send(directed_plan[i].rq, directed_plan[i].typed, directed_plan[i].want);

        run_phase(60, 4'd7,  4'd3,  13, 83, 1'b0);
        run_phase(60, 4'd1,  4'd1,  13, 83, 1'b0);
        run_phase(60, 4'd15, 4'd15, 83, 13, 1'b0);
        run_phase(60, 4'd0,  4'd0,  83, 13, 1'b0);
        run_phase(60, 4'd15, 4'd1,  0,  0,  1'b1);
        run_phase(60, 4'd4,  4'd2,  0,  0,  1'b0);

        settle();
        repeat (6) @(posedge clk);
        if (bad_fields == 0 && status_due.size() == 0)
            $display("rtu_silence_frame_receiver_top regression: pass");
        else
            $display("rtu_silence_frame_receiver_top regression: fail");
        $finish;
    end

    // result side: random back-pressure plus one long hold when kicked
    initial
    begin
        int hold_left;
        int kicks_seen;
        hold_left  = 0;
        kicks_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (kicks_seen != hold_kicks)
            begin
                kicks_seen   = hold_kicks;
                hold_left    = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                $display("%0t: result with nothing expected, length %0d state %0d", $time,
                         rsp_ch.frame_length, rsp_ch.receiver_state);
                bad_fields++;
            end
            else
            begin
                want = status_due.pop_front();
                check_field("frame_ready", 9'(want.frame_ready), 9'(rsp_ch.frame_ready));
                check_field("frame_length", want.frame_length, rsp_ch.frame_length);
                check_field("late_gap_count", 9'(want.late_gap_count),
                            9'(rsp_ch.late_gap_count));
                check_field("read_data", 9'(want.read_data), 9'(rsp_ch.read_data));
                check_field("receiver_state", 9'(want.receiver_state),
                            9'(rsp_ch.receiver_state));
                check_field("overflow", 9'(want.overflow), 9'(rsp_ch.overflow));
            end
        end
    end

    // watchdog: too many cycles without any request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("rtu_silence_frame_receiver_top regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

@@ rtu_silence_frame_receiver_top.f @@
rtl/rsfr_pkg.sv
rtl/rsfr_if.sv
rtl/rsfr_cfg.sv
rtl/rsfr_ctrl.sv
rtl/rsfr_store.sv
rtl/rtu_silence_frame_receiver_top.sv
tb/tb.sv
